>>> src/uflr_pkg.sv
// Shared types and constants for the UART line framer with frame ring.
// Used by every module of uart_line_frame_ring; depends on nothing.
package uflr_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int NUM_W       = 32;
    localparam int SLOT_PORT_W = 4;
    localparam int OFF_PORT_W  = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_TERMINATOR_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPLIT_LENGTH    = 2'd1;

    localparam logic             TERMINATOR_MODE_RESET = 1'b1;
    localparam logic [LEN_W-1:0] SPLIT_LENGTH_RESET    = 7'd50;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [NUM_W-1:0] number;
        logic             continued;
    } slot_meta_t;

    typedef struct packed {
        logic                   done;
        logic [SLOT_PORT_W-1:0] slot;
        logic [LEN_W-1:0]       length;
        logic [NUM_W-1:0]       number;
        logic                   continued;
    } done_info_t;

endpackage

>>> src/uflr_frame_mem.sv
// Byte store for all frame slots: one write port, one registered read port.
// Depends on uflr_pkg.
module uflr_frame_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [uflr_pkg::BYTE_W-1:0] wdata,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [uflr_pkg::BYTE_W-1:0] rdata
);
    import uflr_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/uflr_slot_mem.sv
// Per-slot record of length, number and kind, with a valid bit per slot so
// that a slot never closed reads as zero. Depends on uflr_pkg.
module uflr_slot_mem #(
    parameter int SLOTS  = 16,
    parameter int SLOT_W = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 we,
    input  logic [SLOT_W-1:0]    waddr,
    input  uflr_pkg::slot_meta_t wdata,
    input  logic                 re,
    input  logic [SLOT_W-1:0]    raddr,
    output uflr_pkg::slot_meta_t rdata,
    output logic                 rvalid
);
    import uflr_pkg::*;

    slot_meta_t       mem [SLOTS];
    slot_meta_t       rdata_reg;
    logic [SLOTS-1:0] valid_reg;
    logic             rvalid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata  = rdata_reg;
    assign rvalid = rvalid_reg;

endmodule

>>> src/uflr_rx_ctl.sv
// Framing control: fill position, write slot, frame counter and CR-LF
// detection; issues the store and slot record writes. Depends on uflr_pkg.
module uflr_rx_ctl #(
    parameter int SLOTS       = 16,
    parameter int FRAME_BYTES = 64,
    parameter int SLOT_W      = 4,
    parameter int ADDR_W      = 10
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        rx_en,
    input  logic [uflr_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        terminator_mode,
    input  logic [uflr_pkg::LEN_W-1:0]  split_length,
    output logic                        store_we,
    output logic [ADDR_W-1:0]           store_addr,
    output logic [uflr_pkg::BYTE_W-1:0] store_data,
    output logic                        meta_we,
    output logic [SLOT_W-1:0]           meta_addr,
    output uflr_pkg::slot_meta_t        meta_data,
    output uflr_pkg::done_info_t        done
);
    import uflr_pkg::*;

    localparam int CMP_W = 10;

    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [NUM_W-1:0]  counter_reg, counter_next;
    logic [BYTE_W-1:0] prev_reg, prev_next;

    logic [LEN_W-1:0]  fill_inc;
    logic [NUM_W-1:0]  counter_inc;
    logic [CMP_W-1:0]  limit;
    logic              term;
    logic              split;
    logic              close;

    always_comb begin
        priority if (split_length == '0) begin
            limit = CMP_W'(1);
        end else if (CMP_W'(split_length) > CMP_W'(FRAME_BYTES)) begin
            limit = CMP_W'(FRAME_BYTES);
        end else begin
            limit = CMP_W'(split_length);
        end
    end

    assign fill_inc    = fill_reg + LEN_W'(1);
    assign counter_inc = counter_reg + NUM_W'(1);

    always_comb begin
        if (terminator_mode) begin
            term = (prev_reg == CHAR_CR) && (rx_byte == CHAR_LF);
        end else begin
            term = (rx_byte == CHAR_CR);
        end
        split = !term && (CMP_W'(fill_inc) >= limit);
        close = term || split;
    end

    assign store_we   = rx_en && (CMP_W'(fill_reg) < CMP_W'(FRAME_BYTES));
    assign store_addr = ADDR_W'(write_slot_reg) * ADDR_W'(FRAME_BYTES) + ADDR_W'(fill_reg);
    assign store_data = rx_byte;

    assign meta_we             = rx_en && close;
    assign meta_addr           = write_slot_reg;
    assign meta_data.length    = fill_inc;
    assign meta_data.number    = counter_inc;
    assign meta_data.continued = split;

    always_comb begin
        done = '0;
        if (close) begin
            done.done      = 1'b1;
            done.slot      = SLOT_PORT_W'(write_slot_reg);
            done.length    = fill_inc;
            done.number    = counter_inc;
            done.continued = split;
        end
    end

    always_comb begin
        write_slot_next = write_slot_reg;
        fill_next       = fill_reg;
        counter_next    = counter_reg;
        prev_next       = prev_reg;
        if (rx_en) begin
            prev_next = term ? '0 : rx_byte;
            if (close) begin
                counter_next = counter_inc;
                fill_next    = '0;
                if (write_slot_reg == SLOT_W'(SLOTS - 1)) begin
                    write_slot_next = '0;
                end else begin
                    write_slot_next = write_slot_reg + SLOT_W'(1);
                end
            end else begin
                fill_next = fill_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            write_slot_reg <= '0;
            fill_reg       <= '0;
            counter_reg    <= '0;
            prev_reg       <= '0;
        end else begin
            write_slot_reg <= write_slot_next;
            fill_reg       <= fill_next;
            counter_reg    <= counter_next;
            prev_reg       <= prev_next;
        end
    end

endmodule

>>> src/uart_line_frame_ring.sv
// UART line framer with a ring of frame slots. Received bytes (cmd 0) are
// written straight into the frame store at the current fill position; a
// frame closes on CR, or on CR LF when terminator_mode is 1, or when it
// reaches split_length bytes (then marked continued), and the closed frame's
// slot, length and number come back in that byte's result. A read (cmd 1)
// returns the stored byte at read_slot/read_offset with the slot's recorded
// length and number. One item is accepted every cycle unless the output
// stalls on m_ready; each result passes through the registered read of the
// frame store and slot record memories, then the output register. No clearing
// pass runs after reset; bytes of a slot never written read as undefined. The
// user must write configuration over cfg while idle; the block does not check.
// Depends on uflr_pkg, uflr_rx_ctl, uflr_frame_mem and uflr_slot_mem.
module uart_line_frame_ring #(
    parameter int SLOTS       = 16,
    parameter int FRAME_BYTES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [uflr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uflr_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [uflr_pkg::BYTE_W-1:0]     s_rx_byte,
    input  logic [uflr_pkg::SLOT_PORT_W-1:0] s_read_slot,
    input  logic [uflr_pkg::OFF_PORT_W-1:0]  s_read_offset,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_frame_done,
    output logic [uflr_pkg::SLOT_PORT_W-1:0] m_done_slot,
    output logic [uflr_pkg::LEN_W-1:0]      m_done_length,
    output logic [uflr_pkg::NUM_W-1:0]      m_done_number,
    output logic                            m_done_continued,
    output logic [uflr_pkg::BYTE_W-1:0]     m_read_byte,
    output logic [uflr_pkg::LEN_W-1:0]      m_read_length,
    output logic [uflr_pkg::NUM_W-1:0]      m_read_number
);
    import uflr_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int DEPTH  = SLOTS * FRAME_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = 10;

    logic             term_mode_reg;
    logic [LEN_W-1:0] split_len_reg;

    logic accept;
    logic rx_en;
    logic rd_en;
    logic slot_ok;
    logic off_ok;
    logic load_out;

    logic              store_we;
    logic [ADDR_W-1:0] store_addr;
    logic [BYTE_W-1:0] store_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_byte;
    logic              meta_we;
    logic [SLOT_W-1:0] meta_addr;
    slot_meta_t        meta_wdata;
    slot_meta_t        meta_rdata;
    logic              meta_rvalid;
    done_info_t        done;

    logic       s1_valid_reg;
    logic       s1_cmd_reg;
    logic       s1_slot_ok_reg;
    logic       s1_off_ok_reg;
    done_info_t s1_done_reg;

    logic              m_valid_reg;
    done_info_t        m_done_reg;
    logic [BYTE_W-1:0] m_byte_reg;
    logic [LEN_W-1:0]  m_len_reg;
    logic [NUM_W-1:0]  m_num_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_mode_reg <= TERMINATOR_MODE_RESET;
            split_len_reg <= SPLIT_LENGTH_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_TERMINATOR_MODE) begin
                term_mode_reg <= cfg_data[0];
            end else if (cfg_index == REG_SPLIT_LENGTH) begin
                split_len_reg <= cfg_data;
            end
        end
    end

    assign load_out = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || load_out;
    assign accept   = s_valid && s_ready;
    assign rx_en    = accept && (s_cmd == CMD_RECEIVE);
    assign rd_en    = accept && (s_cmd == CMD_READ);
    assign slot_ok  = CMP_W'(s_read_slot) < CMP_W'(SLOTS);
    assign off_ok   = CMP_W'(s_read_offset) < CMP_W'(FRAME_BYTES);
    assign rd_addr  = ADDR_W'(s_read_slot) * ADDR_W'(FRAME_BYTES) + ADDR_W'(s_read_offset);

    uflr_rx_ctl #(
        .SLOTS       (SLOTS),
        .FRAME_BYTES (FRAME_BYTES),
        .SLOT_W      (SLOT_W),
        .ADDR_W      (ADDR_W)
    ) u_rx_ctl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .rx_en           (rx_en),
        .rx_byte         (s_rx_byte),
        .terminator_mode (term_mode_reg),
        .split_length    (split_len_reg),
        .store_we        (store_we),
        .store_addr      (store_addr),
        .store_data      (store_data),
        .meta_we         (meta_we),
        .meta_addr       (meta_addr),
        .meta_data       (meta_wdata),
        .done            (done)
    );

    uflr_frame_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_frame_mem (
        .aclk  (aclk),
        .we    (store_we),
        .waddr (store_addr),
        .wdata (store_data),
        .re    (rd_en && slot_ok && off_ok),
        .raddr (rd_addr),
        .rdata (rd_byte)
    );

    uflr_slot_mem #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_slot_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (meta_we),
        .waddr   (meta_addr),
        .wdata   (meta_wdata),
        .re      (rd_en && slot_ok),
        .raddr   (SLOT_W'(s_read_slot)),
        .rdata   (meta_rdata),
        .rvalid  (meta_rvalid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (load_out) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cmd_reg     <= s_cmd;
            s1_slot_ok_reg <= slot_ok;
            s1_off_ok_reg  <= off_ok;
            s1_done_reg    <= (s_cmd == CMD_RECEIVE) ? done : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_done_reg <= s1_done_reg;
            m_byte_reg <= '0;
            m_len_reg  <= '0;
            m_num_reg  <= '0;
            if (s1_cmd_reg == CMD_READ && s1_slot_ok_reg) begin
                if (s1_off_ok_reg) begin
                    m_byte_reg <= rd_byte;
                end
                if (meta_rvalid) begin
                    m_len_reg <= meta_rdata.length;
                    m_num_reg <= meta_rdata.number;
                end
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_frame_done     = m_done_reg.done;
    assign m_done_slot      = m_done_reg.slot;
    assign m_done_length    = m_done_reg.length;
    assign m_done_number    = m_done_reg.number;
    assign m_done_continued = m_done_reg.continued;
    assign m_read_byte      = m_byte_reg;
    assign m_read_length    = m_len_reg;
    assign m_read_number    = m_num_reg;

endmodule

>>> sim/tb_uart_line_frame_ring.sv
// Self-checking testbench for uart_line_frame_ring: a queue-fed driver, a monitor and a
// cycle-free predictor of the framer and its slot ring, compared on every result item.
// Depends on uflr_pkg and the uart_line_frame_ring RTL.
`timescale 1ns / 100ps

module tb_uart_line_frame_ring;
    import uflr_pkg::*;

    localparam int SLOTS        = 16;
    localparam int FRAME_BYTES  = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic                   cmd;
        logic [BYTE_W-1:0]      rx_byte;
        logic [SLOT_PORT_W-1:0] read_slot;
        logic [OFF_PORT_W-1:0]  read_offset;
    } line_item_t;

    typedef struct packed {
        logic                   frame_done;
        logic [SLOT_PORT_W-1:0] done_slot;
        logic [LEN_W-1:0]       done_length;
        logic [NUM_W-1:0]       done_number;
        logic                   done_continued;
        logic [BYTE_W-1:0]      read_byte;
        logic [LEN_W-1:0]       read_length;
        logic [NUM_W-1:0]       read_number;
    } line_result_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic                   s_cmd         = 1'b0;
    logic [BYTE_W-1:0]      s_rx_byte     = '0;
    logic [SLOT_PORT_W-1:0] s_read_slot   = '0;
    logic [OFF_PORT_W-1:0]  s_read_offset = '0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic                   m_frame_done;
    logic [SLOT_PORT_W-1:0] m_done_slot;
    logic [LEN_W-1:0]       m_done_length;
    logic [NUM_W-1:0]       m_done_number;
    logic                   m_done_continued;
    logic [BYTE_W-1:0]      m_read_byte;
    logic [LEN_W-1:0]       m_read_length;
    logic [NUM_W-1:0]       m_read_number;

    line_item_t   pending_items[$];
    line_result_t results_due[$];
    line_item_t   cur_item;
    int           s_idle_pct = 27;
    int           m_idle_pct = 67;
    int           items_pushed = 0;
    int           items_sent = 0;
    int           results_seen = 0;
    int           errors = 0;
    int           stall_cycles = 0;
    int           frames_closed = 0;
    int           frames_split = 0;
    int           reads_sent = 0;

    // Predictor state: frame ring contents, slot records and framer position.
    logic [BYTE_W-1:0] ring_bytes[0:SLOTS*FRAME_BYTES-1];
    bit                is_filled[0:SLOTS*FRAME_BYTES-1];
    int                filled_addrs[$];
    logic [LEN_W-1:0]  ring_len[0:SLOTS-1] = '{default: '0};
    logic [NUM_W-1:0]  ring_num[0:SLOTS-1] = '{default: '0};
    int                head_slot = 0;
    int                fill_level = 0;
    logic [NUM_W-1:0]  frame_count = '0;
    logic [BYTE_W-1:0] last_byte = '0;
    logic              eol_mode = TERMINATOR_MODE_RESET;
    logic [LEN_W-1:0]  split_reg = SPLIT_LENGTH_RESET;

    uart_line_frame_ring #(
        .SLOTS       (SLOTS),
        .FRAME_BYTES (FRAME_BYTES)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_rx_byte        (s_rx_byte),
        .s_read_slot      (s_read_slot),
        .s_read_offset    (s_read_offset),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_done     (m_frame_done),
        .m_done_slot      (m_done_slot),
        .m_done_length    (m_done_length),
        .m_done_number    (m_done_number),
        .m_done_continued (m_done_continued),
        .m_read_byte      (m_read_byte),
        .m_read_length    (m_read_length),
        .m_read_number    (m_read_number)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic line_result_t frame_step(input line_item_t it);
        line_result_t r;
        int           addr;
        int           lim;
        bit           term;
        bit           cut;
        r = '0;
        if (it.cmd == CMD_READ) begin
            addr          = int'(it.read_slot) * FRAME_BYTES + int'(it.read_offset);
            r.read_byte   = ring_bytes[addr];
            r.read_length = ring_len[it.read_slot];
            r.read_number = ring_num[it.read_slot];
            reads_sent++;
        end else begin
            if (fill_level < FRAME_BYTES) begin
                addr             = head_slot * FRAME_BYTES + fill_level;
                ring_bytes[addr] = it.rx_byte;
                if (!is_filled[addr]) begin
                    is_filled[addr] = 1'b1;
                    filled_addrs.push_back(addr);
                end
            end
            fill_level++;
            if (eol_mode)
                term = (last_byte == CHAR_CR) && (it.rx_byte == CHAR_LF);
            else
                term = (it.rx_byte == CHAR_CR);
            lim = int'(split_reg);
            if (lim < 1)
                lim = 1;
            else if (lim > FRAME_BYTES)
                lim = FRAME_BYTES;
            cut = !term && (fill_level >= lim);
            if (term || cut) begin
                frame_count          = frame_count + NUM_W'(1);
                ring_len[head_slot]  = LEN_W'(fill_level);
                ring_num[head_slot]  = frame_count;
                r.frame_done         = 1'b1;
                r.done_slot          = SLOT_PORT_W'(head_slot);
                r.done_length        = LEN_W'(fill_level);
                r.done_number        = frame_count;
                r.done_continued     = cut;
                head_slot            = (head_slot + 1) % SLOTS;
                fill_level           = 0;
                frames_closed++;
                if (cut)
                    frames_split++;
            end
            last_byte = term ? 8'h00 : it.rx_byte;
        end
        return r;
    endfunction

    task automatic push_item(input line_item_t it);
        while (pending_items.size() >= 4)
            @(posedge aclk);
        pending_items.push_back(it);
        items_pushed++;
    endtask

    task automatic push_rx(input logic [BYTE_W-1:0] b);
        line_item_t it;
        it.cmd         = CMD_RECEIVE;
        it.rx_byte     = b;
        it.read_slot   = SLOT_PORT_W'($urandom_range(0, SLOTS - 1));
        it.read_offset = OFF_PORT_W'($urandom_range(0, FRAME_BYTES - 1));
        push_item(it);
    endtask

    task automatic push_read(input int addr);
        line_item_t it;
        it.cmd         = CMD_READ;
        it.rx_byte     = BYTE_W'($urandom_range(0, 255));
        it.read_slot   = SLOT_PORT_W'(addr / FRAME_BYTES);
        it.read_offset = OFF_PORT_W'(addr % FRAME_BYTES);
        push_item(it);
    endtask

    // Mostly well-formed lines with random text, plus reads of stored bytes and raw noise.
    task automatic random_traffic(input int count);
        int left;
        int pick;
        int len;
        left = count;
        while (left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 22 && filled_addrs.size() != 0) begin
                push_read(filled_addrs[$urandom_range(0, filled_addrs.size() - 1)]);
                left--;
            end else if (pick < 34) begin
                case ($urandom_range(0, 3))
                    0:       push_rx(CHAR_CR);
                    1:       push_rx(CHAR_LF);
                    default: push_rx(BYTE_W'($urandom_range(0, 255)));
                endcase
                left--;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
                                                  : $urandom_range(0, 12);
                repeat (len)
                    push_rx(BYTE_W'($urandom_range(32, 126)));
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    push_rx(CHAR_CR);
                    if (eol_mode)
                        push_rx(CHAR_LF);
                end else if (pick < 9) begin
                    push_rx(CHAR_CR);
                end else begin
                    push_rx(CHAR_LF);
                end
                left -= len + 1;
            end
        end
    endtask

    task automatic wait_quiet();
        do
            @(posedge aclk);
        while (items_pushed != items_sent || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TERMINATOR_MODE: eol_mode  = val[0];
            REG_SPLIT_LENGTH:    split_reg = val;
            default: ;
        endcase
    endtask

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR: %s", msg);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                results_due.push_back(frame_step(cur_item));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= s_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_valid       <= 1'b1;
                    s_cmd         <= cur_item.cmd;
                    s_rx_byte     <= cur_item.rx_byte;
                    s_read_slot   <= cur_item.read_slot;
                    s_read_offset <= cur_item.read_offset;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        line_result_t want;
        line_result_t got;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_frame_done, m_done_slot, m_done_length, m_done_number,
                       m_done_continued, m_read_byte, m_read_length, m_read_number};
                if (results_due.size() == 0) begin
                    note_error($sformatf("result item %0d arrived with nothing expected",
                                         results_seen));
                end else begin
                    want = results_due.pop_front();
                    if (got !== want)
                        note_error($sformatf({"result item %0d: expected done=%0d slot=%0d ",
                            "len=%0d num=%0d cont=%0d byte=%02h rlen=%0d rnum=%0d, got ",
                            "done=%0d slot=%0d len=%0d num=%0d cont=%0d byte=%02h rlen=%0d ",
                            "rnum=%0d"}, results_seen,
                            want.frame_done, want.done_slot, want.done_length,
                            want.done_number, want.done_continued, want.read_byte,
                            want.read_length, want.read_number,
                            got.frame_done, got.done_slot, got.done_length,
                            got.done_number, got.done_continued, got.read_byte,
                            got.read_length, got.read_number));
                end
                results_seen++;
            end
            m_ready <= ($urandom_range(0, 99) >= m_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: CR LF terminator, split at 50.
        push_rx(8'h00);
        push_rx(8'hFF);
        push_rx("A");
        push_rx(CHAR_CR);
        push_rx(CHAR_LF);
        push_rx(CHAR_LF);
        push_rx(CHAR_CR);
        push_rx(CHAR_CR);
        push_rx(CHAR_LF);
        push_read(0);
        push_read(1);
        push_read(FRAME_BYTES + 3);
        random_traffic(160);
        push_rx(CHAR_CR);
        push_rx(CHAR_LF);
        wait_quiet();

        // A CR that ends a split frame pairs with the LF that opens the next one.
        write_reg(REG_SPLIT_LENGTH, 7'd3);
        push_rx("a");
        push_rx("b");
        push_rx(CHAR_CR);
        push_rx(CHAR_LF);
        random_traffic(45);
        wait_quiet();

        // Lowering the split length below the current fill closes on the next byte.
        s_idle_pct = 67;
        m_idle_pct = 27;
        write_reg(REG_SPLIT_LENGTH, 7'd64);
        repeat (20) push_rx("x");
        wait_quiet();
        write_reg(REG_SPLIT_LENGTH, 7'd10);
        push_rx("y");
        random_traffic(70);
        wait_quiet();
        write_reg(REG_SPLIT_LENGTH, 7'd64);
        random_traffic(55);
        wait_quiet();

        // Lone CR mode with split 1: the terminator wins on the split byte.
        write_reg(REG_TERMINATOR_MODE, 7'd0);
        write_reg(REG_SPLIT_LENGTH, 7'd1);
        push_rx(CHAR_CR);
        push_rx("q");
        random_traffic(45);
        wait_quiet();

        // Out-of-range split lengths clamp to the ends of the range.
        s_idle_pct = 0;
        m_idle_pct = 0;
        write_reg(REG_SPLIT_LENGTH, 7'd0);
        random_traffic(30);
        wait_quiet();
        write_reg(REG_TERMINATOR_MODE, 7'd1);
        write_reg(REG_SPLIT_LENGTH, 7'd127);
        random_traffic(130);
        wait_quiet();

        $display("Covered %0d items: %0d frames closed (%0d by split length), %0d reads,",
                 items_sent, frames_closed, frames_split, reads_sent);
        $display("both terminator modes and split lengths 0, 1, 3, 10, 50, 64 and 127.");
        if (errors == 0 && results_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d errors", errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
src/uflr_pkg.sv
src/uflr_frame_mem.sv
src/uflr_slot_mem.sv
src/uflr_rx_ctl.sv
src/uart_line_frame_ring.sv
sim/tb_uart_line_frame_ring.sv
